[hw/rtl/ecsm_pkg.sv]
package ecsm_pkg;

    // Configuration register indexes
    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t REG_FIELD_PRIME = 2'd0;
    localparam cfg_index_t REG_CURVE_A     = 2'd1;
    localparam cfg_index_t REG_CURVE_ORDER = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [19:0] {
        ST_IDLE   = 20'b0000_0000_0000_0000_0001,
        ST_MUL    = 20'b0000_0000_0000_0000_0010,
        ST_DIV    = 20'b0000_0000_0000_0000_0100,
        ST_RK     = 20'b0000_0000_0000_0000_1000,
        ST_RX     = 20'b0000_0000_0000_0001_0000,
        ST_RY     = 20'b0000_0000_0000_0010_0000,
        ST_RA     = 20'b0000_0000_0000_0100_0000,
        ST_SCAN   = 20'b0000_0000_0000_1000_0000,
        ST_DBL    = 20'b0000_0000_0001_0000_0000,
        ST_SQ     = 20'b0000_0000_0010_0000_0000,
        ST_NUM    = 20'b0000_0000_0100_0000_0000,
        ST_ESTART = 20'b0000_0000_1000_0000_0000,
        ST_EQ     = 20'b0000_0001_0000_0000_0000,
        ST_ET     = 20'b0000_0010_0000_0000_0000,
        ST_LAM    = 20'b0000_0100_0000_0000_0000,
        ST_RXS    = 20'b0000_1000_0000_0000_0000,
        ST_RYS    = 20'b0001_0000_0000_0000_0000,
        ST_ADD    = 20'b0010_0000_0000_0000_0000,
        ST_NXT    = 20'b0100_0000_0000_0000_0000,
        ST_OUT    = 20'b1000_0000_0000_0000_0000
    } state_t;

endpackage

[hw/rtl/ecsm_in_if.sv]
interface ecsm_in_if #(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 32
);
    logic                   valid;
    logic                   ready;
    logic [FIELD_BITS-1:0]  base_x;
    logic [FIELD_BITS-1:0]  base_y;
    logic [SCALAR_BITS-1:0] scalar;

    modport source (output valid, base_x, base_y, scalar, input ready);
    modport sink   (input valid, base_x, base_y, scalar, output ready);
endinterface

[hw/rtl/ecsm_out_if.sv]
interface ecsm_out_if #(
    parameter int FIELD_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [FIELD_BITS-1:0] result_x;
    logic [FIELD_BITS-1:0] result_y;
    logic                  at_infinity;

    modport source (output valid, result_x, result_y, at_infinity, input ready);
    modport sink   (input valid, result_x, result_y, at_infinity, output ready);
endinterface

[hw/rtl/ec_point_scalar_multiply.sv]
// Sequence: the scalar is reduced mod n and x, y and a mod p; the scalar is then scanned
//   for its top set bit, which loads the base point; for each lower bit the point is doubled
//   and, if the bit is set, the base point added (slope inverse by extended Euclid).
// Throughput: one transfer at a time; in ready only in idle. The bit-serial
//   remainder unit, shared by every modular reduction and division, limits the rate.
// Reset: asynchronous, active low; config returns to p=17, a=2, n=19, block idle.
module ec_point_scalar_multiply #(
    parameter int FIELD_BITS  = 16,
    parameter int SCALAR_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  ecsm_pkg::cfg_index_t        cfg_index,
    input  logic [FIELD_BITS:0]         cfg_data,
    ecsm_in_if.sink                     din,
    ecsm_out_if.source                  dout
);
    import ecsm_pkg::*;

    localparam int F  = FIELD_BITS;
    localparam int S  = SCALAR_BITS;
    localparam int W  = (2 * F > S) ? 2 * F : S;   // dividend width of the remainder unit
    localparam int CW = $clog2(W + 1);
    localparam int IW = $clog2(S);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [F-1:0] prime_reg;
    logic [F-1:0] coef_a_reg;
    logic [F:0]   order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prime_reg  <= F'(17);
            coef_a_reg <= F'(2);
            order_reg  <= (F + 1)'(19);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FIELD_PRIME: prime_reg  <= cfg_data[F-1:0];
                REG_CURVE_A:     coef_a_reg <= cfg_data[F-1:0];
                REG_CURVE_ORDER: order_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Clamp modulus and order to their legal minimum
    logic [F-1:0] p_eff;
    logic [F:0]   n_eff;
    assign p_eff = (prime_reg < F'(3)) ? F'(3) : prime_reg;
    assign n_eff = (order_reg < (F + 1)'(2)) ? (F + 1)'(2) : order_reg;

    // Modular add / subtract on reduced operands
    function automatic logic [F-1:0] add_mod(logic [F-1:0] u, logic [F-1:0] v,
                                             logic [F-1:0] m);
        logic [F:0] s;
        s = {1'b0, u} + {1'b0, v};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[F-1:0];
    endfunction

    function automatic logic [F-1:0] sub_mod(logic [F-1:0] u, logic [F-1:0] v,
                                             logic [F-1:0] m);
        logic [F-1:0] d;
        if (u >= v)
            d = u - v;
        else
            d = u + (m - v);
        return d;
    endfunction

    // ---------------------------------------------------------------
    // Sequencer and datapath registers
    // ---------------------------------------------------------------
    state_t         state_reg, state_next;
    state_t         ret_reg, ret_next;          // continuation after MUL/DIV
    logic [F-1:0]   ma_reg, ma_next;            // multiplier operands
    logic [F-1:0]   mb_reg, mb_next;
    logic [W-1:0]   dvd_reg, dvd_next;          // dividend, MSB first
    logic [F:0]     dm_reg, dm_next;            // divisor
    logic [F:0]     rem_reg, rem_next;
    logic [F-1:0]   quo_reg, quo_next;
    logic [CW-1:0]  cnt_reg, cnt_next;

    logic [F-1:0]   x_in_reg, x_in_next;
    logic [F-1:0]   y_in_reg, y_in_next;
    logic [S-1:0]   k_reg, k_next;
    logic [F-1:0]   p_reg, p_next;
    logic [F-1:0]   a_reg, a_next;
    logic [F-1:0]   bx_reg, bx_next;
    logic [F-1:0]   by_reg, by_next;
    logic [F-1:0]   ax_reg, ax_next;
    logic [F-1:0]   ay_reg, ay_next;
    logic           ainf_reg, ainf_next;
    logic [F-1:0]   tx_reg, tx_next;            // x of second operand
    logic [F-1:0]   num_reg, num_next;
    logic [F-1:0]   den_reg, den_next;
    logic [F-1:0]   lam_reg, lam_next;
    logic [F-1:0]   r1_reg, r1_next;            // Euclid remainders
    logic [F-1:0]   rm_reg, rm_next;
    logic [F-1:0]   t0_reg, t0_next;            // Euclid coefficients, kept mod p
    logic [F-1:0]   t1_reg, t1_next;
    logic [IW-1:0]  idx_reg, idx_next;
    logic           addph_reg, addph_next;      // current op is the add of a bit

    logic           ov_reg, ov_next;
    logic [F-1:0]   ox_reg, ox_next;
    logic [F-1:0]   oy_reg, oy_next;
    logic           oinf_reg, oinf_next;

    // Shared remainder step
    logic [F+1:0]   trial;
    logic           qbit;
    logic [2*F-1:0] prod;
    logic [F-1:0]   rx_c;
    logic [F-1:0]   res_f;

    assign trial = {rem_reg, dvd_reg[W-1]};
    assign qbit  = (trial >= {1'b0, dm_reg});
    assign prod  = ma_reg * mb_reg;
    assign res_f = rem_reg[F-1:0];
    assign rx_c  = sub_mod(sub_mod(res_f, ax_reg, p_reg), tx_reg, p_reg);

    assign din.ready        = (state_reg == ST_IDLE);
    assign dout.valid       = ov_reg;
    assign dout.result_x    = ox_reg;
    assign dout.result_y    = oy_reg;
    assign dout.at_infinity = oinf_reg;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        ma_next    = ma_reg;
        mb_next    = mb_reg;
        dvd_next   = dvd_reg;
        dm_next    = dm_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        x_in_next  = x_in_reg;
        y_in_next  = y_in_reg;
        k_next     = k_reg;
        p_next     = p_reg;
        a_next     = a_reg;
        bx_next    = bx_reg;
        by_next    = by_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        ainf_next  = ainf_reg;
        tx_next    = tx_reg;
        num_next   = num_reg;
        den_next   = den_reg;
        lam_next   = lam_reg;
        r1_next    = r1_reg;
        rm_next    = rm_reg;
        t0_next    = t0_reg;
        t1_next    = t1_reg;
        idx_next   = idx_reg;
        addph_next = addph_reg;
        ov_next    = ov_reg;
        ox_next    = ox_reg;
        oy_next    = oy_reg;
        oinf_next  = oinf_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (din.valid)
                begin
                    x_in_next  = din.base_x;
                    y_in_next  = din.base_y;
                    p_next     = p_eff;
                    ainf_next  = 1'b1;
                    ax_next    = '0;
                    ay_next    = '0;
                    // scalar mod n
                    dvd_next   = W'(din.scalar) << (W - S);
                    cnt_next   = CW'(S);
                    dm_next    = n_eff;
                    rem_next   = '0;
                    ret_next   = ST_RK;
                    state_next = ST_DIV;
                end
            end

            ST_MUL:
            begin
                dvd_next   = W'(prod) << (W - 2 * F);
                cnt_next   = CW'(2 * F);
                dm_next    = {1'b0, p_reg};
                rem_next   = '0;
                state_next = ST_DIV;
            end

            ST_DIV:
            begin
                rem_next = qbit ? (trial[F:0] - dm_reg) : trial[F:0];
                quo_next = {quo_reg[F-2:0], qbit};
                dvd_next = dvd_reg << 1;
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                    state_next = ret_reg;
            end

            ST_RK:
            begin
                k_next     = S'(rem_reg);
                dvd_next   = W'(x_in_reg) << (W - F);
                cnt_next   = CW'(F);
                dm_next    = {1'b0, p_reg};
                rem_next   = '0;
                ret_next   = ST_RX;
                state_next = ST_DIV;
            end

            ST_RX:
            begin
                bx_next    = res_f;
                dvd_next   = W'(y_in_reg) << (W - F);
                cnt_next   = CW'(F);
                rem_next   = '0;
                ret_next   = ST_RY;
                state_next = ST_DIV;
            end

            ST_RY:
            begin
                by_next    = res_f;
                dvd_next   = W'(coef_a_reg) << (W - F);
                cnt_next   = CW'(F);
                rem_next   = '0;
                ret_next   = ST_RA;
                state_next = ST_DIV;
            end

            ST_RA:
            begin
                a_next     = res_f;
                idx_next   = IW'(S - 1);
                state_next = ST_SCAN;
            end

            // Find the top set bit; it loads the base point
            ST_SCAN:
            begin
                if (k_reg[idx_reg])
                begin
                    ax_next   = bx_reg;
                    ay_next   = by_reg;
                    ainf_next = 1'b0;
                    if (idx_reg == '0)
                        state_next = ST_OUT;
                    else
                    begin
                        idx_next   = idx_reg - IW'(1);
                        addph_next = 1'b0;
                        state_next = ST_DBL;
                    end
                end
                else if (idx_reg == '0)
                    state_next = ST_OUT;
                else
                    idx_next = idx_reg - IW'(1);
            end

            ST_DBL:
            begin
                if (ainf_reg)
                    state_next = ST_NXT;
                else
                begin
                    tx_next    = ax_reg;
                    ma_next    = ax_reg;
                    mb_next    = ax_reg;
                    ret_next   = ST_SQ;
                    state_next = ST_MUL;
                end
            end

            ST_ADD:
            begin
                if (ainf_reg)
                begin
                    ax_next    = bx_reg;
                    ay_next    = by_reg;
                    ainf_next  = 1'b0;
                    state_next = ST_NXT;
                end
                else if (ax_reg == bx_reg && ay_reg == by_reg)
                begin
                    // same point: doubling slope
                    tx_next    = ax_reg;
                    ma_next    = ax_reg;
                    mb_next    = ax_reg;
                    ret_next   = ST_SQ;
                    state_next = ST_MUL;
                end
                else if (ax_reg == bx_reg)
                begin
                    ainf_next  = 1'b1;
                    state_next = ST_NXT;
                end
                else
                begin
                    tx_next    = bx_reg;
                    num_next   = sub_mod(ay_reg, by_reg, p_reg);
                    den_next   = sub_mod(ax_reg, bx_reg, p_reg);
                    state_next = ST_ESTART;
                end
            end

            ST_SQ:
            begin
                ma_next    = F'(3);
                mb_next    = res_f;
                ret_next   = ST_NUM;
                state_next = ST_MUL;
            end

            ST_NUM:
            begin
                num_next   = add_mod(res_f, a_reg, p_reg);
                den_next   = add_mod(ay_reg, ay_reg, p_reg);
                state_next = ST_ESTART;
            end

            // Extended Euclid: r0 = p, r1 = den
            ST_ESTART:
            begin
                if (den_reg == '0)
                begin
                    ainf_next  = 1'b1;
                    state_next = ST_NXT;
                end
                else
                begin
                    r1_next    = den_reg;
                    t0_next    = '0;
                    t1_next    = F'(1);
                    dvd_next   = W'(p_reg) << (W - F);
                    cnt_next   = CW'(F);
                    dm_next    = {1'b0, den_reg};
                    rem_next   = '0;
                    ret_next   = ST_EQ;
                    state_next = ST_DIV;
                end
            end

            ST_EQ:
            begin
                rm_next    = res_f;
                ma_next    = quo_reg;
                mb_next    = t1_reg;
                ret_next   = ST_ET;
                state_next = ST_MUL;
            end

            ST_ET:
            begin
                t0_next = t1_reg;
                t1_next = sub_mod(t0_reg, res_f, p_reg);
                r1_next = rm_reg;
                if (rm_reg == '0)
                begin
                    if (r1_reg == F'(1))
                    begin
                        ma_next    = num_reg;
                        mb_next    = t1_reg;
                        ret_next   = ST_LAM;
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        ainf_next  = 1'b1;
                        state_next = ST_NXT;
                    end
                end
                else
                begin
                    dvd_next   = W'(r1_reg) << (W - F);
                    cnt_next   = CW'(F);
                    dm_next    = {1'b0, rm_reg};
                    rem_next   = '0;
                    ret_next   = ST_EQ;
                    state_next = ST_DIV;
                end
            end

            ST_LAM:
            begin
                lam_next   = res_f;
                ma_next    = res_f;
                mb_next    = res_f;
                ret_next   = ST_RXS;
                state_next = ST_MUL;
            end

            ST_RXS:
            begin
                tx_next    = rx_c;             // tx no longer needed; holds new x
                ma_next    = lam_reg;
                mb_next    = sub_mod(ax_reg, rx_c, p_reg);
                ret_next   = ST_RYS;
                state_next = ST_MUL;
            end

            ST_RYS:
            begin
                ax_next    = tx_reg;
                ay_next    = sub_mod(res_f, ay_reg, p_reg);
                ainf_next  = 1'b0;
                state_next = ST_NXT;
            end

            ST_NXT:
            begin
                if (!addph_reg && k_reg[idx_reg])
                begin
                    addph_next = 1'b1;
                    state_next = ST_ADD;
                end
                else if (idx_reg == '0)
                    state_next = ST_OUT;
                else
                begin
                    idx_next   = idx_reg - IW'(1);
                    addph_next = 1'b0;
                    state_next = ST_DBL;
                end
            end

            ST_OUT:
            begin
                if (!ov_reg)
                begin
                    ov_next    = 1'b1;
                    ox_next    = ainf_reg ? '0 : ax_reg;
                    oy_next    = ainf_reg ? '0 : ay_reg;
                    oinf_next  = ainf_reg;
                    state_next = ST_IDLE;
                end
            end

            default:
                state_next = ST_IDLE;
        endcase

        // output transfer
        if (ov_reg && dout.ready)
            ov_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            ov_reg    <= 1'b0;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            addph_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            ov_reg    <= ov_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            addph_reg <= addph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        dvd_reg  <= dvd_next;
        dm_reg   <= dm_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        x_in_reg <= x_in_next;
        y_in_reg <= y_in_next;
        k_reg    <= k_next;
        p_reg    <= p_next;
        a_reg    <= a_next;
        bx_reg   <= bx_next;
        by_reg   <= by_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        ainf_reg <= ainf_next;
        tx_reg   <= tx_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        lam_reg  <= lam_next;
        r1_reg   <= r1_next;
        rm_reg   <= rm_next;
        t0_reg   <= t0_next;
        t1_reg   <= t1_next;
        ox_reg   <= ox_next;
        oy_reg   <= oy_next;
        oinf_reg <= oinf_next;
    end

endmodule
